### design/mbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants of the Mandelbrot escape iteration block.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int LIMIT_RESET = 255;

  typedef enum logic {
    PT_ITERATE,
    PT_OUTSIDE
  } pt_class_e;

  typedef struct packed {
    logic      valid;
    pt_class_e cls;
  } q_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_RR,
    S_II,
    S_SUM,
    S_CHK,
    S_DONE
  } eng_state_e;

endpackage

### design/mbe_point_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_point_if
// Input channel: one complex point c per item.
// ----------------------------------------------------------------------------
interface mbe_point_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] c_real;
  logic signed [COORD_WIDTH-1:0] c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

### design/mbe_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_result_if
// Output channel: escape count and in-set flag per item.
// ----------------------------------------------------------------------------
interface mbe_result_if #(
  parameter int COUNT_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [COUNT_WIDTH-1:0] iter_count;
  logic                   in_set;

  modport source (output valid, output iter_count, output in_set, input ready);
  modport sink   (input valid, input iter_count, input in_set, output ready);
endinterface

### design/mbe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_front
// Accepts points, flags those that escape on the first step, and holds
// them in a two-entry queue for the iteration engine.
// ----------------------------------------------------------------------------
module mbe_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mbe_point_if.sink                     point_i,
  output mbe_pkg::q_ctrl_t              q_ctrl_o,
  output logic signed [COORD_WIDTH-1:0] q_cr_o,
  output logic signed [COORD_WIDTH-1:0] q_ci_o,
  input  logic                          q_ready_i
);
  import mbe_pkg::*;

  localparam logic signed [COORD_WIDTH-1:0] LIM_POS =
    COORD_WIDTH'(1) << (COORD_WIDTH - 3);
  localparam logic signed [COORD_WIDTH-1:0] LIM_NEG = -LIM_POS;

  logic signed [COORD_WIDTH-1:0] cr_mem [QDEPTH];
  logic signed [COORD_WIDTH-1:0] ci_mem [QDEPTH];
  pt_class_e                     cls_mem [QDEPTH];

  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   fill_q, fill_d;
  logic              push, pop;
  pt_class_e         cls_in;

  always_comb begin
    if (point_i.c_real >= LIM_POS || point_i.c_real <= LIM_NEG ||
        point_i.c_imag >= LIM_POS || point_i.c_imag <= LIM_NEG) begin
      cls_in = PT_OUTSIDE;
    end else begin
      cls_in = PT_ITERATE;
    end
  end

  assign point_i.ready = (fill_q != (QPTR_W+1)'(QDEPTH));
  assign push          = point_i.valid && point_i.ready;
  assign pop           = q_ctrl_o.valid && q_ready_i;

  assign q_ctrl_o.valid = (fill_q != '0);
  assign q_ctrl_o.cls   = cls_mem[rd_ptr_q];
  assign q_cr_o         = cr_mem[rd_ptr_q];
  assign q_ci_o         = ci_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cr_mem[wr_ptr_q]  <= point_i.c_real;
      ci_mem[wr_ptr_q]  <= point_i.c_imag;
      cls_mem[wr_ptr_q] <= cls_in;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (QPTR_W+1)'(QDEPTH))
    else $error("queue fill above depth");

  a_fill_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> fill_q == $past(fill_q) + 1'b1)
    else $error("queue fill not advanced on push");

  a_fill_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> fill_q == $past(fill_q) - 1'b1)
    else $error("queue fill not reduced on pop");

endmodule

### design/mbe_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_engine
// Runs z = z*z + c on one shared multiplier until escape, repeat of |z|^2
// or the iteration limit, then hands the result to the output register.
// ----------------------------------------------------------------------------
module mbe_engine #(
  parameter int COORD_WIDTH = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [COUNT_WIDTH-1:0]        limit_i,
  input  mbe_pkg::q_ctrl_t              q_ctrl_i,
  input  logic signed [COORD_WIDTH-1:0] q_cr_i,
  input  logic signed [COORD_WIDTH-1:0] q_ci_i,
  output logic                          q_ready_o,
  mbe_result_if.source                  result_o
);
  import mbe_pkg::*;

  localparam int F  = COORD_WIDTH - 4;
  localparam int ZW = F + 2;
  localparam int PW = 2 * ZW;
  localparam int SW = F + 3;
  localparam int TW = F + 4;
  localparam int NW = COORD_WIDTH + 1;

  localparam logic signed [NW-1:0] BOUND_POS = NW'(1) << (F + 1);
  localparam logic signed [NW-1:0] BOUND_NEG = -BOUND_POS;
  localparam logic [TW-1:0]        FOUR      = TW'(1) << (F + 2);
  localparam logic signed [ZW-1:0] Z_MIN     = ZW'(1) << (ZW - 1);

  eng_state_e state_q, state_d;

  logic signed [COORD_WIDTH-1:0] cr_q, ci_q;
  logic signed [ZW-1:0]          re_q, im_q;
  logic [SW-1:0]                 sre_q, sim_q;
  logic [TW-1:0]                 sum_q, last_q;
  logic signed [PW-1:0]          prod_q;
  logic [COUNT_WIDTH-1:0]        count_q;
  logic [COUNT_WIDTH-1:0]        fin_count_q;
  logic                          fin_in_q;

  logic                   res_valid_q;
  logic [COUNT_WIDTH-1:0] res_count_q;
  logic                   res_in_q;

  logic signed [ZW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_d;
  logic signed [PW-1:0] prod_sq, prod_ri;
  logic [SW-1:0]        sq_val;
  logic signed [TW-1:0] ri_val;
  logic signed [NW-1:0] nre, nim;
  logic                 upd_escape;
  logic                 chk_repeat, chk_escape, chk_limit;
  logic                 slot_free, res_load;

  assign prod_sq = prod_q >>> F;
  assign prod_ri = prod_q >>> (F - 1);
  assign sq_val  = prod_sq[SW-1:0];
  assign ri_val  = prod_ri[TW-1:0];

  assign nre = $signed({2'b00, sre_q}) - $signed({2'b00, sim_q}) + {cr_q[COORD_WIDTH-1], cr_q};
  assign nim = {ri_val[TW-1], ri_val} + {ci_q[COORD_WIDTH-1], ci_q};

  assign upd_escape = nre >= BOUND_POS || nre <= BOUND_NEG ||
                      nim >= BOUND_POS || nim <= BOUND_NEG;
  assign chk_repeat = (sum_q == last_q);
  assign chk_escape = (sum_q >= FOUR);
  assign chk_limit  = (count_q >= limit_i);
  assign slot_free  = !res_valid_q || result_o.ready;

  assign prod_d = mul_a * mul_b;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_ctrl_i.valid) begin
          state_d = (q_ctrl_i.cls == PT_OUTSIDE) ? S_DONE : S_UPD;
        end
      end
      S_UPD: begin
        state_d = upd_escape ? S_DONE : S_RR;
      end
      S_RR:  state_d = S_II;
      S_II:  state_d = S_SUM;
      S_SUM: state_d = S_CHK;
      S_CHK: begin
        state_d = (chk_repeat || chk_escape || chk_limit) ? S_DONE : S_UPD;
      end
      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_ready_o = 1'b0;
    res_load  = 1'b0;
    mul_a     = re_q;
    mul_b     = im_q;
    unique case (state_q)
      S_IDLE: q_ready_o = 1'b1;
      S_RR: begin
        mul_a = re_q;
        mul_b = re_q;
      end
      S_II: begin
        mul_a = im_q;
        mul_b = im_q;
      end
      S_DONE: res_load = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= (state_q == S_IDLE) ? '0 : prod_d;
    case (state_q)
      S_IDLE: begin
        cr_q        <= q_cr_i;
        ci_q        <= q_ci_i;
        re_q        <= '0;
        im_q        <= '0;
        sre_q       <= '0;
        sim_q       <= '0;
        sum_q       <= '0;
        count_q     <= '0;
        fin_count_q <= '0;
        fin_in_q    <= 1'b0;
      end
      S_UPD: begin
        re_q   <= nre[ZW-1:0];
        im_q   <= nim[ZW-1:0];
        last_q <= sum_q;
        if (upd_escape) begin
          fin_count_q <= count_q;
          fin_in_q    <= 1'b0;
        end
      end
      S_II: sre_q <= sq_val;
      S_SUM: begin
        sim_q <= sq_val;
        sum_q <= {1'b0, sre_q} + {1'b0, sq_val};
      end
      S_CHK: begin
        if (chk_repeat || (!chk_escape && chk_limit)) begin
          fin_count_q <= limit_i;
          fin_in_q    <= 1'b1;
        end else if (chk_escape) begin
          fin_count_q <= count_q;
          fin_in_q    <= 1'b0;
        end else begin
          count_q <= count_q + 1'b1;
        end
      end
      default: ;
    endcase
    if (res_load) begin
      res_count_q <= fin_count_q;
      res_in_q    <= fin_in_q;
    end
  end

  assign result_o.valid      = res_valid_q;
  assign result_o.iter_count = res_count_q;
  assign result_o.in_set     = res_in_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!res_valid_q || result_o.ready))
    else $error("result register overwritten while held");

  a_z_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RR || state_q == S_II || state_q == S_SUM || state_q == S_CHK)
      |-> (re_q != Z_MIN && im_q != Z_MIN))
    else $error("z component outside escape bound");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_ready_o && q_ctrl_i.valid) |=> (state_q == S_UPD || state_q == S_DONE))
    else $error("popped item not started");

endmodule

### design/mandelbrot_escape_iteration.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_iteration
// Escape-time iteration of one complex point per item, with a configurable
// iteration limit.
//
//   channel     dir  handshake          payload
//   point_i     in   valid/ready        c_real, c_imag (signed Q4.28)
//   result_o    out  valid/ready        iter_count, in_set
//   cfg         in   cfg_we_i           cfg_wdata_i -> iteration limit
//
// Each iteration runs update, three products and check on the shared
// multiplier; a point also ends at the update when a component leaves
// the bound, and a point with a component of magnitude 2 or more goes
// straight to the result without iterating. A two-entry queue accepts
// points while one runs, and the output register holds a result while
// the next point starts; a held result keeps the engine waiting once the
// next point is done.
// Reset clears the queue, the engine state and sets the limit to 255.
// ----------------------------------------------------------------------------
module mandelbrot_escape_iteration #(
  parameter int COORD_WIDTH = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [COUNT_WIDTH-1:0] cfg_wdata_i,
  mbe_point_if.sink              point_i,
  mbe_result_if.source           result_o
);
  import mbe_pkg::*;

  logic [COUNT_WIDTH-1:0]        limit_q;
  q_ctrl_t                       q_ctrl;
  logic signed [COORD_WIDTH-1:0] q_cr, q_ci;
  logic                          q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= COUNT_WIDTH'(LIMIT_RESET);
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  mbe_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .point_i  (point_i),
    .q_ctrl_o (q_ctrl),
    .q_cr_o   (q_cr),
    .q_ci_o   (q_ci),
    .q_ready_i(q_ready)
  );

  mbe_engine #(
    .COORD_WIDTH(COORD_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .limit_i  (limit_q),
    .q_ctrl_i (q_ctrl),
    .q_cr_i   (q_cr),
    .q_ci_i   (q_ci),
    .q_ready_o(q_ready),
    .result_o (result_o)
  );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for mandelbrot_escape_iteration. Points are sent over
// the point channel and checked against a fixed-point escape-time predictor
// that tracks the iteration limit. Directed points cover the field extremes,
// immediate escape, the zero point, escape on the final step and the limit
// extremes. Random points, mostly inside the interesting region, follow under
// several limits with source gaps and sink stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int COORD_W = 32;
  localparam int COUNT_W = 16;
  localparam int FRAC    = COORD_W - 4;

  localparam logic signed [COORD_W-1:0] ONE     = 32'sh1000_0000;
  localparam logic signed [COORD_W-1:0] TWO     = 32'sh2000_0000;
  localparam logic signed [COORD_W-1:0] HALF    = 32'sh0800_0000;
  localparam logic signed [COORD_W-1:0] QUARTER = 32'sh0400_0000;
  localparam logic signed [COORD_W-1:0] NEAR_Q  = 32'sd69793219;
  localparam logic signed [COORD_W-1:0] C_MAX   = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] C_MIN   = 32'sh8000_0000;

  typedef struct packed {
    logic [COUNT_W-1:0] iter_count;
    logic               in_set;
  } escape_t;

  class escape_scoreboard;
    escape_t            expected_q[$];
    logic [COUNT_W-1:0] limit;
    int                 failures;
    int                 checked;
    int                 in_set_seen;

    function new();
      limit       = COUNT_W'(mbe_pkg::LIMIT_RESET);
      failures    = 0;
      checked     = 0;
      in_set_seen = 0;
    endfunction

    function longint fixed_mul(longint a, longint b, int sh);
      logic signed [127:0] wa, wb, p;
      wa = 128'(a);
      wb = 128'(b);
      p  = wa * wb;
      p  = p >>> sh;
      return p[63:0];
    endfunction

    function escape_t predict_escape(logic signed [COORD_W-1:0] c_re,
                                     logic signed [COORD_W-1:0] c_im);
      longint      cr, ci, re, im, nre, sq_re, sq_im, mag, prev_mag, bound, four;
      int unsigned n;
      escape_t     r;
      cr    = longint'(c_re);
      ci    = longint'(c_im);
      bound = longint'(2) <<< FRAC;
      four  = longint'(4) <<< FRAC;
      re    = 0;
      im    = 0;
      sq_re = 0;
      sq_im = 0;
      mag   = 0;
      n     = 0;
      forever begin
        nre      = sq_re - sq_im + cr;
        im       = fixed_mul(re, im, FRAC - 1) + ci;
        re       = nre;
        prev_mag = mag;
        if (re >= bound || re <= -bound || im >= bound || im <= -bound) begin
          r.iter_count = COUNT_W'(n);
          r.in_set     = 1'b0;
          break;
        end
        sq_re = fixed_mul(re, re, FRAC);
        sq_im = fixed_mul(im, im, FRAC);
        mag   = sq_re + sq_im;
        if (mag == prev_mag) begin
          r.iter_count = limit;
          r.in_set     = 1'b1;
          break;
        end
        if (mag >= four) begin
          r.iter_count = COUNT_W'(n);
          r.in_set     = 1'b0;
          break;
        end
        if (n >= limit) begin
          r.iter_count = limit;
          r.in_set     = 1'b1;
          break;
        end
        n++;
      end
      return r;
    endfunction

    function void note_point(logic signed [COORD_W-1:0] c_re,
                             logic signed [COORD_W-1:0] c_im);
      expected_q.push_back(predict_escape(c_re, c_im));
    endfunction

    function void check_result(logic [COUNT_W-1:0] cnt, logic flag);
      escape_t want;
      checked++;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: iter_count %0d in_set %0d", cnt, flag);
        return;
      end
      want = expected_q.pop_front();
      if (flag) in_set_seen++;
      if (want.iter_count !== cnt || want.in_set !== flag) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected iter_count %0d in_set %0d, got %0d %0d",
                   want.iter_count, want.in_set, cnt, flag);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_ni;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;
  int                 src_idle_pct;
  int                 snk_stall_pct;
  int                 hold_off;
  int                 n_limits;

  escape_scoreboard sb = new();

  mbe_point_if  #(.COORD_WIDTH(COORD_W)) point_bus ();
  mbe_result_if #(.COUNT_WIDTH(COUNT_W)) result_bus ();

  mandelbrot_escape_iteration #(
    .COORD_WIDTH(COORD_W),
    .COUNT_WIDTH(COUNT_W)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .point_i    (point_bus),
    .result_o   (result_bus)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("mandelbrot_escape_iteration verification failed");
    $finish;
  end

  // sink side, ready changes at the falling edge
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        result_bus.ready <= 1'b0;
        hold_off--;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni && result_bus.valid && result_bus.ready)
      sb.check_result(result_bus.iter_count, result_bus.in_set);
  end

  task automatic send_point(logic signed [COORD_W-1:0] c_re,
                            logic signed [COORD_W-1:0] c_im);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      point_bus.valid <= 1'b0;
    end
    @(negedge clk);
    point_bus.valid  <= 1'b1;
    point_bus.c_real <= c_re;
    point_bus.c_imag <= c_im;
    @(posedge clk);
    while (!point_bus.ready) @(posedge clk);
    sb.note_point(c_re, c_im);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    point_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [COUNT_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.limit = value;
    n_limits++;
  endtask

  task automatic send_random_point();
    logic signed [COORD_W-1:0] c_re, c_im;
    if ($urandom_range(99) < 80) begin
      // box around the set, -2..0.5 by -1.25..1.25
      c_re = $signed($urandom_range(0, 671088640)) - 32'sd536870912;
      c_im = $signed($urandom_range(0, 671088640)) - 32'sd335544320;
    end else begin
      c_re = $urandom();
      c_im = $urandom();
    end
    send_point(c_re, c_im);
  endtask

  task automatic run_phase(int n, int idle_pct, int stall_pct,
                           logic [COUNT_W-1:0] lim);
    wait_drained();
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    write_limit(lim);
    repeat (n) send_random_point();
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    point_bus.valid  = 1'b0;
    point_bus.c_real = '0;
    point_bus.c_imag = '0;
    src_idle_pct     = 0;
    snk_stall_pct    = 0;
    hold_off         = 0;
    n_limits         = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // reset limit
    send_point(0, 0);
    send_point(C_MAX, C_MAX);
    send_point(C_MIN, C_MIN);
    send_point(TWO, 0);
    send_point(-TWO, 0);
    send_point(0, TWO);
    send_point(0, -TWO);
    send_point(TWO - 1, 0);
    send_point(-(TWO - 1), 0);
    send_point(-ONE, 0);
    send_point(0, ONE);
    send_point(QUARTER, 0);
    send_point(NEAR_Q, 0);
    send_point(1, -1);
    send_point($urandom(), $urandom());

    // smallest limit, escape on the final step
    wait_drained();
    write_limit(COUNT_W'(1));
    send_point(ONE, 0);
    send_point(-ONE, 0);
    send_point(0, 0);
    send_point(HALF, HALF);

    // largest limit
    wait_drained();
    write_limit(16'hffff);
    send_point(0, 0);
    send_point(NEAR_Q, 0);
    send_point(C_MIN, C_MAX);
    send_point(-ONE, 0);

    // long sink hold-off with fast escaping items queued behind it
    wait_drained();
    write_limit(COUNT_W'(mbe_pkg::LIMIT_RESET));
    @(posedge clk);
    hold_off = 300;
    repeat (10) send_point(C_MAX, $urandom());
    wait_drained();

    run_phase(150, 0, 0, COUNT_W'(255));
    run_phase(150, 78, 0, COUNT_W'(1));
    run_phase(150, 0, 78, COUNT_W'(40));
    run_phase(150, 25, 25, COUNT_W'(255));

    wait_drained();
    repeat (20) @(posedge clk);
    $display("%0d results checked over %0d limit settings, %0d inside the set",
             sb.checked, n_limits, sb.in_set_seen);
    $display("limits 1 to 65535, idle and stall phases, one long sink hold-off");
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("mandelbrot_escape_iteration verification clean");
    end else begin
      $display("%0d failures, %0d results missing", sb.failures, sb.pending());
      $display("mandelbrot_escape_iteration verification failed");
    end
    $finish;
  end

endmodule

### sim.f
design/mbe_pkg.sv
design/mbe_point_if.sv
design/mbe_result_if.sv
design/mbe_front.sv
design/mbe_engine.sv
design/mandelbrot_escape_iteration.sv
verif/testbench.sv
